FILE: sv/rfmpi_pkg.sv
// shared types and constants for the route filter merge block
`timescale 1ns / 1ps

package rfmpi_pkg;

    // input item operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERFACES   = 1'd1;

    // field widths fixed by the interface
    localparam int DEST_W   = 8;
    localparam int IFACE_W  = 4;
    localparam int FILTER_W = 64;
    localparam int BYTES_W  = 4;
    localparam int NIF_W    = 5;

    // reset values of the configuration registers
    localparam logic [BYTES_W-1:0] FILTER_BYTES_RESET = 4'd8;
    localparam logic [NIF_W-1:0]   INTERFACES_RESET   = 5'd16;

    // most results reported per query list
    localparam int RESULT_LIMIT = 16;

    // one pending result word from the sequencer
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               used;
        logic [IFACE_W-1:0] index;
    } emit_t;

endpackage

FILE: sv/rfmpi_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module rfmpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/rfmpi_seq.sv
// sequencer: route lookup, accumulator read-modify-write and result walk
`timescale 1ns / 1ps

module rfmpi_seq #(
    parameter int MAX_DESTINATIONS = 256,
    parameter int MAX_INTERFACES   = 16,
    parameter int FILTER_BITS      = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input channel control
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   op,
    input  logic [rfmpi_pkg::DEST_W-1:0]           destination,
    input  logic                                   last_destination,
    // output channel control
    input  logic                                   out_stall,
    output rfmpi_pkg::emit_t                       emit,
    // configuration
    input  logic [rfmpi_pkg::NIF_W-1:0]            cfg_interfaces,
    input  logic [FILTER_BITS-1:0]                 mask,
    // route table
    output logic                                   rt_we,
    output logic                                   rt_re,
    output logic [(MAX_DESTINATIONS > 1 ? $clog2(MAX_DESTINATIONS) : 1)-1:0] rt_addr,
    input  logic [rfmpi_pkg::IFACE_W-1:0]          rt_iface,
    input  logic [FILTER_BITS-1:0]                 rt_filter,
    // accumulator memory
    output logic                                   acc_we,
    output logic [(MAX_INTERFACES > 1 ? $clog2(MAX_INTERFACES) : 1)-1:0] acc_waddr,
    output logic [FILTER_BITS-1:0]                 acc_wdata,
    output logic                                   acc_re,
    output logic [(MAX_INTERFACES > 1 ? $clog2(MAX_INTERFACES) : 1)-1:0] acc_raddr,
    input  logic [FILTER_BITS-1:0]                 acc_rdata
);

    localparam int DEST_AW = (MAX_DESTINATIONS > 1) ? $clog2(MAX_DESTINATIONS) : 1;
    localparam int IF_AW   = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
    localparam int LIM     = (MAX_INTERFACES < rfmpi_pkg::RESULT_LIMIT) ?
                             MAX_INTERFACES : rfmpi_pkg::RESULT_LIMIT;
    localparam int CNT_W   = rfmpi_pkg::NIF_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROUTE = 2'd1;
    localparam logic [1:0] S_ACC   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic                          hit_reg;
    logic                          last_reg;
    logic                          acc_hit_reg;
    logic [IF_AW-1:0]              acc_addr_reg;
    logic [MAX_INTERFACES-1:0]     mark_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          pend_reg;
    logic [rfmpi_pkg::IFACE_W-1:0] idx_reg;
    logic                          used_reg;
    logic                          lastout_reg;

    logic             take_ok;
    logic             in_take;
    logic             query_take;
    logic             dest_ok;
    logic             ri_ok;
    logic [CNT_W-1:0] n_lim;
    logic             out_take;
    logic             issue;
    logic             emit_done;

    always_comb
    begin
        take_ok    = (state_reg == S_IDLE) || ((state_reg == S_ACC) && !last_reg);
        in_take    = in_valid && take_ok;
        query_take = in_take && (op == rfmpi_pkg::OP_QUERY);
        dest_ok    = 32'(destination) < 32'(MAX_DESTINATIONS);
        ri_ok      = hit_reg && (32'(rt_iface) < 32'(MAX_INTERFACES));
        n_lim      = (cfg_interfaces > CNT_W'(LIM)) ? CNT_W'(LIM) : cfg_interfaces;
        out_take   = pend_reg && !out_stall;
        issue      = (state_reg == S_EMIT) && (cnt_reg < n_lim) && (!pend_reg || out_take);
        emit_done  = (state_reg == S_EMIT) && (cnt_reg >= n_lim) && (!pend_reg || out_take);
    end

    assign in_stall = !take_ok;

    // route table access on acceptance
    assign rt_we   = in_take && (op == rfmpi_pkg::OP_WRITE) && dest_ok;
    assign rt_re   = query_take;
    assign rt_addr = DEST_AW'(destination);

    // accumulator port: rmw read in route state, result walk in emit state
    assign acc_re    = ((state_reg == S_ROUTE) && ri_ok) || issue;
    assign acc_raddr = (state_reg == S_ROUTE) ? IF_AW'(rt_iface) : IF_AW'(cnt_reg);
    assign acc_we    = (state_reg == S_ACC) && acc_hit_reg;
    assign acc_waddr = acc_addr_reg;
    // unmarked entries read as zero
    assign acc_wdata = (mark_reg[acc_addr_reg] ? acc_rdata : '0) | (rt_filter & mask);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (query_take)
                begin
                    state_next = S_ROUTE;
                end
            end
            S_ROUTE:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (last_reg)
                begin
                    state_next = S_EMIT;
                end
                else if (query_take)
                begin
                    state_next = S_ROUTE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            hit_reg     <= 1'b0;
            last_reg    <= 1'b0;
            acc_hit_reg <= 1'b0;
            mark_reg    <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (query_take)
            begin
                hit_reg  <= dest_ok;
                last_reg <= last_destination;
            end
            if (state_reg == S_ROUTE)
            begin
                acc_hit_reg <= ri_ok;
            end
            if (acc_we)
            begin
                mark_reg[acc_addr_reg] <= 1'b1;
            end
            if ((state_reg == S_ACC) && last_reg)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (issue)
            begin
                pend_reg <= 1'b1;
            end
            else if (out_take)
            begin
                pend_reg <= 1'b0;
            end
            if (emit_done)
            begin
                mark_reg <= '0;
            end
        end
    end

    // payload side of the pipeline, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROUTE)
        begin
            acc_addr_reg <= IF_AW'(rt_iface);
        end
        if (issue)
        begin
            idx_reg     <= rfmpi_pkg::IFACE_W'(cnt_reg);
            used_reg    <= mark_reg[IF_AW'(cnt_reg)];
            lastout_reg <= (cnt_reg + 1'b1) == n_lim;
        end
    end

    assign emit.valid = pend_reg;
    assign emit.last  = lastout_reg;
    assign emit.used  = used_reg;
    assign emit.index = idx_reg;

    a_pend_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_EMIT))
        else $error("result pending outside emit state");

    a_route_read_then_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        rt_re |=> (state_reg == S_ROUTE))
        else $error("route read not followed by lookup");

    a_marks_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && $past(state_reg) == S_EMIT) |-> (mark_reg == '0))
        else $error("interface marks not cleared after result walk");

    a_acc_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
        acc_we |=> mark_reg[$past(acc_addr_reg)])
        else $error("accumulator write left entry unmarked");

endmodule

FILE: sv/route_filter_merge_per_interface_top.sv
// top level of the per-interface route filter merge block
`timescale 1ns / 1ps

// route table with per-interface bloom filter merge. a write word (op 0) stores
// the interface index and filter bits of one destination. a query word (op 1)
// looks up its destination and ors the route's filter bits, cut to
// filter_bytes_in_use bytes, into that interface's accumulator. a query passes
// through route table read, accumulator read and accumulator write back; the
// next query can be taken during the write back of the one before it. after a
// query flagged last_destination, the block stops taking words and emits one
// result per reported interface, 0 up to min(interfaces_in_use, MAX_INTERFACES,
// RESULT_LIMIT)-1, one per cycle while the output is not stalled, then clears
// all marks and returns to idle. routes live in a MAX_DESTINATIONS x
// (4 + FILTER_BITS) ram, accumulators in a MAX_INTERFACES x FILTER_BITS ram
// with one mark flop per interface; there is no clearing pass after reset.
// querying a never-written destination is not allowed. the user must write
// configuration only while the block is idle; the block does not enforce it.
module route_filter_merge_per_interface_top #(
    parameter int MAX_DESTINATIONS = 256,
    parameter int MAX_INTERFACES   = 16,
    parameter int FILTER_BITS      = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [rfmpi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rfmpi_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [rfmpi_pkg::DEST_W-1:0]        destination,
    input  logic [rfmpi_pkg::IFACE_W-1:0]       route_interface,
    input  logic [rfmpi_pkg::FILTER_W-1:0]      route_filter,
    input  logic                                last_destination,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rfmpi_pkg::IFACE_W-1:0]       interface_index,
    output logic                                interface_used,
    output logic [rfmpi_pkg::FILTER_W-1:0]      filter_bits,
    output logic                                last_result
);

    localparam int DEST_AW = (MAX_DESTINATIONS > 1) ? $clog2(MAX_DESTINATIONS) : 1;
    localparam int IF_AW   = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
    localparam int RT_W    = rfmpi_pkg::IFACE_W + FILTER_BITS;

    // configuration registers
    logic [rfmpi_pkg::BYTES_W-1:0] fb_reg;
    logic [rfmpi_pkg::NIF_W-1:0]   nif_reg;

    // byte mask for merge and report
    logic [FILTER_BITS-1:0] mask;

    // route table signals
    logic               rt_we;
    logic               rt_re;
    logic [DEST_AW-1:0] rt_addr;
    logic [RT_W-1:0]    rt_wdata;
    logic [RT_W-1:0]    rt_rdata;

    // accumulator signals
    logic                   acc_we;
    logic [IF_AW-1:0]       acc_waddr;
    logic [FILTER_BITS-1:0] acc_wdata;
    logic                   acc_re;
    logic [IF_AW-1:0]       acc_raddr;
    logic [FILTER_BITS-1:0] acc_rdata;

    rfmpi_pkg::emit_t       emit;
    logic [FILTER_BITS-1:0] filt_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_reg  <= rfmpi_pkg::FILTER_BYTES_RESET;
            nif_reg <= rfmpi_pkg::INTERFACES_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rfmpi_pkg::CFG_FILTER_BYTES:
                begin
                    fb_reg <= cfg_data[rfmpi_pkg::BYTES_W-1:0];
                end
                rfmpi_pkg::CFG_INTERFACES:
                begin
                    nif_reg <= cfg_data[rfmpi_pkg::NIF_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // bit i is kept when its byte lies below the configured byte count;
    // saturates naturally at the filter width
    always_comb
    begin
        for (int i = 0; i < FILTER_BITS; i++)
        begin
            mask[i] = rfmpi_pkg::BYTES_W'(i >> 3) < fb_reg;
        end
    end

    // route entry: interface index above the filter bits
    assign rt_wdata = {route_interface, route_filter[FILTER_BITS-1:0]};

    rfmpi_ram #(
        .WIDTH (RT_W),
        .DEPTH (MAX_DESTINATIONS)
    ) u_route_ram (
        .clk   (clk),
        .we    (rt_we),
        .waddr (rt_addr),
        .wdata (rt_wdata),
        .re    (rt_re),
        .raddr (rt_addr),
        .rdata (rt_rdata)
    );

    rfmpi_ram #(
        .WIDTH (FILTER_BITS),
        .DEPTH (MAX_INTERFACES)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    rfmpi_seq #(
        .MAX_DESTINATIONS (MAX_DESTINATIONS),
        .MAX_INTERFACES   (MAX_INTERFACES),
        .FILTER_BITS      (FILTER_BITS)
    ) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .destination      (destination),
        .last_destination (last_destination),
        .out_stall        (out_stall),
        .emit             (emit),
        .cfg_interfaces   (nif_reg),
        .mask             (mask),
        .rt_we            (rt_we),
        .rt_re            (rt_re),
        .rt_addr          (rt_addr),
        .rt_iface         (rt_rdata[RT_W-1 -: rfmpi_pkg::IFACE_W]),
        .rt_filter        (rt_rdata[FILTER_BITS-1:0]),
        .acc_we           (acc_we),
        .acc_waddr        (acc_waddr),
        .acc_wdata        (acc_wdata),
        .acc_re           (acc_re),
        .acc_raddr        (acc_raddr),
        .acc_rdata        (acc_rdata)
    );

    // accumulator read data holds while the result word is stalled;
    // an unmarked interface reports no bits
    assign filt_out = emit.used ? (acc_rdata & mask) : '0;

    assign out_valid       = emit.valid;
    assign interface_index = emit.index;
    assign interface_used  = emit.used;
    assign last_result     = emit.last;
    assign filter_bits     = rfmpi_pkg::FILTER_W'(filt_out);

endmodule
